// File: design/rcpt_pkg.sv
// Shared types, constants and register codes for the RC pulse decoder.
`default_nettype none

package rcpt_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VALID_LOW  = 3'd0,
        REG_VALID_HIGH = 3'd1,
        REG_DEAD_LOW   = 3'd2,
        REG_DEAD_HIGH  = 3'd3,
        REG_SPAN_MIN   = 3'd4,
        REG_SPAN_MAX   = 3'd5,
        REG_LIMIT      = 3'd6,
        REG_TIMEOUT    = 3'd7
    } t_reg_idx;

    // Register values after reset.
    localparam logic [15:0] RST_VALID_LOW  = 16'd1000;
    localparam logic [15:0] RST_VALID_HIGH = 16'd2000;
    localparam logic [15:0] RST_DEAD_LOW   = 16'd1435;
    localparam logic [15:0] RST_DEAD_HIGH  = 16'd1465;
    localparam logic [15:0] RST_SPAN_MIN   = 16'd1100;
    localparam logic [15:0] RST_SPAN_MAX   = 16'd1800;
    localparam logic [14:0] RST_LIMIT      = 15'd15000;
    localparam logic [23:0] RST_TIMEOUT    = 24'd200000;

    // Event codes carried in the action field.
    localparam logic ACT_EDGE   = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // Iterative divider: quotient bits resolved per cycle and cycle count.
    localparam int DIV_Q_W     = 32;
    localparam int DIV_D_W     = 16;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_ITERS   = DIV_Q_W / DIV_STEPS;
    localparam int DIV_CNT_W   = $clog2(DIV_ITERS);

    // Saturation bounds of the 16-bit target.
    localparam logic signed [33:0] TGT_MAX = 34'sd32767;
    localparam logic signed [33:0] TGT_MIN = -34'sd32768;

    typedef struct packed {
        logic        action;
        logic [31:0] time_us;
        logic        pin_level;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] target_milli;
        logic               signal_valid;
        logic               signal_lost;
        logic [15:0]        pulse_width_us;
    } t_out_item;

    typedef struct packed {
        logic [15:0] valid_low_us;
        logic [15:0] valid_high_us;
        logic [15:0] dead_low_us;
        logic [15:0] dead_high_us;
        logic [15:0] span_min_us;
        logic [15:0] span_max_us;
        logic [14:0] target_limit_milli;
        logic [23:0] timeout_us;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_edge;
        logic take_update;
        logic mul;
        logic div_start;
        logic fix;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic map_needed;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: design/rcpt_regs.sv
// Configuration register file of the RC pulse decoder.
`default_nettype none

module rcpt_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rcpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rcpt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rcpt_pkg::t_cfg                       o_cfg
);
    import rcpt_pkg::*;

    t_cfg r_cfg;

    // Registers load on a write strobe; each keeps only its own width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valid_low_us       <= RST_VALID_LOW;
            r_cfg.valid_high_us      <= RST_VALID_HIGH;
            r_cfg.dead_low_us        <= RST_DEAD_LOW;
            r_cfg.dead_high_us       <= RST_DEAD_HIGH;
            r_cfg.span_min_us        <= RST_SPAN_MIN;
            r_cfg.span_max_us        <= RST_SPAN_MAX;
            r_cfg.target_limit_milli <= RST_LIMIT;
            r_cfg.timeout_us         <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_VALID_LOW:  r_cfg.valid_low_us       <= i_cfg_data[15:0];
                REG_VALID_HIGH: r_cfg.valid_high_us      <= i_cfg_data[15:0];
                REG_DEAD_LOW:   r_cfg.dead_low_us        <= i_cfg_data[15:0];
                REG_DEAD_HIGH:  r_cfg.dead_high_us       <= i_cfg_data[15:0];
                REG_SPAN_MIN:   r_cfg.span_min_us        <= i_cfg_data[15:0];
                REG_SPAN_MAX:   r_cfg.span_max_us        <= i_cfg_data[15:0];
                REG_LIMIT:      r_cfg.target_limit_milli <= i_cfg_data[14:0];
                REG_TIMEOUT:    r_cfg.timeout_us         <= i_cfg_data[23:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: design/rcpt_div.sv
// Iterative unsigned divider, DIV_STEPS quotient bits per cycle.
`default_nettype none

module rcpt_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [rcpt_pkg::DIV_Q_W-1:0] i_dividend,
    input  wire logic [rcpt_pkg::DIV_D_W-1:0] i_divisor,
    output logic                              o_done,
    output logic [rcpt_pkg::DIV_Q_W-1:0]      o_quotient
);
    import rcpt_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_Q_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_dsr;
    logic [DIV_Q_W-1:0]   n_quo;
    logic [DIV_D_W-1:0]   n_rem;

    // Restoring division: the dividend shifts out of the top of the quotient
    // register while quotient bits shift in at the bottom.
    always_comb begin
        logic [DIV_D_W:0] trial;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {n_rem, n_quo[DIV_Q_W-1]};
            n_quo = {n_quo[DIV_Q_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dsr}) begin
                trial    = trial - {1'b0, r_dsr};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[DIV_D_W-1:0];
        end
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_busy && (r_cnt == DIV_CNT_W'(DIV_ITERS - 1));
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: design/rcpt_dp.sv
// Datapath: pulse timing state, timeout check, linear mapping and result register.
`default_nettype none

module rcpt_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rcpt_pkg::t_dp_cmd    i_cmd,
    output rcpt_pkg::t_dp_status      o_status,
    input  wire rcpt_pkg::t_cfg       i_cfg,
    input  wire rcpt_pkg::t_in_item   i_in_data,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output rcpt_pkg::t_out_item       o_out_data
);
    import rcpt_pkg::*;

    logic [31:0]        r_rise;
    logic [31:0]        r_last_edge;
    logic [31:0]        r_width;
    logic               r_valid_flag;
    logic               r_lost;
    logic               r_map;
    logic               r_neg;
    logic [15:0]        r_diff_mag;
    logic [15:0]        r_den_mag;
    logic [31:0]        r_num_mag;
    logic signed [32:0] r_qs;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [31:0]        s_elapsed;
    logic               s_lost;
    logic [31:0]        s_new_width;
    logic               s_in_dead;
    logic [16:0]        s_diff;
    logic [16:0]        s_diff_neg;
    logic [16:0]        s_den;
    logic [16:0]        s_den_neg;
    logic               s_map;
    logic [15:0]        s_lim2;
    logic               s_div_done;
    logic [31:0]        s_quo;
    logic signed [33:0] s_t;
    logic signed [15:0] s_target;
    logic [15:0]        s_width_sat;

    // Timeout check and pulse width measurement, modulo 2^32.
    assign s_elapsed   = i_in_data.time_us - r_last_edge;
    assign s_lost      = s_elapsed > {8'd0, i_cfg.timeout_us};
    assign s_new_width = i_in_data.time_us - r_rise;

    // Mapping operands: a valid width is below 65535, so its low half is exact.
    assign s_in_dead  = (r_width > {16'd0, i_cfg.dead_low_us})
                     && (r_width < {16'd0, i_cfg.dead_high_us});
    assign s_diff     = {1'b0, r_width[15:0]} - {1'b0, i_cfg.span_min_us};
    assign s_diff_neg = 17'd0 - s_diff;
    assign s_den      = {1'b0, i_cfg.span_max_us} - {1'b0, i_cfg.span_min_us};
    assign s_den_neg  = 17'd0 - s_den;
    assign s_map      = r_valid_flag && !s_lost && !s_in_dead
                     && (i_cfg.span_max_us != i_cfg.span_min_us);
    assign s_lim2     = {i_cfg.target_limit_milli, 1'b0};

    // Pulse state updates on edge and update events.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise       <= '0;
            r_last_edge  <= '0;
            r_width      <= '0;
            r_valid_flag <= 1'b0;
        end else if (i_cmd.take_edge) begin
            r_last_edge <= i_in_data.time_us;
            if (i_in_data.pin_level) begin
                r_rise <= i_in_data.time_us;
            end else begin
                r_width      <= s_new_width;
                r_valid_flag <= (s_new_width > {16'd0, i_cfg.valid_low_us})
                             && (s_new_width < {16'd0, i_cfg.valid_high_us});
            end
        end else if (i_cmd.take_update && s_lost) begin
            r_valid_flag <= 1'b0;
        end
    end

    // Mapping pipeline: magnitudes and sign, product, signed quotient.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_update) begin
            r_lost     <= s_lost;
            r_map      <= s_map;
            r_neg      <= s_diff[16] ^ s_den[16];
            r_diff_mag <= s_diff[16] ? s_diff_neg[15:0] : s_diff[15:0];
            r_den_mag  <= s_den[16] ? s_den_neg[15:0] : s_den[15:0];
        end
        if (i_cmd.mul) begin
            r_num_mag <= 32'(r_diff_mag) * 32'(s_lim2);
        end
        if (i_cmd.fix) begin
            r_qs <= r_neg ? (33'sd0 - $signed({1'b0, s_quo})) : $signed({1'b0, s_quo});
        end
    end

    rcpt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_num_mag),
        .i_divisor  (r_den_mag),
        .o_done     (s_div_done),
        .o_quotient (s_quo)
    );

    // Offset by the limit and saturate to 16 bits; the target is zero when no mapping is needed.
    assign s_t = {r_qs[32], r_qs} - $signed({19'd0, i_cfg.target_limit_milli});
    always_comb begin
        if (!r_map) begin
            s_target = '0;
        end else if (s_t > TGT_MAX) begin
            s_target = TGT_MAX[15:0];
        end else if (s_t < TGT_MIN) begin
            s_target = TGT_MIN[15:0];
        end else begin
            s_target = s_t[15:0];
        end
    end

    assign s_width_sat = (|r_width[31:16]) ? 16'hFFFF : r_width[15:0];

    // Result register: holds a finished result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.target_milli   <= s_target;
            r_out.signal_valid   <= r_valid_flag;
            r_out.signal_lost    <= r_lost;
            r_out.pulse_width_us <= s_width_sat;
        end
    end

    assign o_status.map_needed = r_map;
    assign o_status.div_done   = s_div_done;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out;

endmodule

`default_nettype wire

// File: design/rcpt_ctrl.sv
// Controller state machine sequencing events through the datapath.
`default_nettype none

module rcpt_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_action,
    output logic                      o_in_ready,
    output rcpt_pkg::t_dp_cmd         o_cmd,
    input  wire rcpt_pkg::t_dp_status i_status
);
    import rcpt_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action == ACT_UPDATE) begin
                        o_cmd.take_update = 1'b1;
                        n_state           = ST_MUL;
                    end else begin
                        o_cmd.take_edge = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                if (i_status.map_needed) begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_DSTART;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/rc_pulse_to_signed_target_unit.sv
// Top level of the RC pulse decoder: registers, controller and datapath.
//
// Decodes a radio-control servo pulse from timestamped pin edge events and
// reports a signed target in thousandths on each periodic update event. An
// edge event gives no result. An update event gives one result, offered
// after the MUL and OUT states when no mapping is needed (signal invalid,
// lost, inside the deadband or zero span), and after MUL, DSTART, DIV, FIX
// and OUT when the width is mapped, through a 16x16 multiply and an iterative
// 32/16 divider resolving four quotient bits per cycle. The next event is
// taken in the cycle after the result is loaded. The result register frees
// the controller once loaded, so the next event is taken while the result
// still waits for its transfer; an update waits in its final step only when
// the previous result has not yet been taken.
// Configuration is written through a plain write port; the user must write it
// only while the block is idle, as the block itself does not enforce it.
`default_nettype none

module rc_pulse_to_signed_target_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire rcpt_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output rcpt_pkg::t_out_item                  o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [rcpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rcpt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rcpt_pkg::*;

    t_cfg       s_cfg;
    t_dp_cmd    s_cmd;
    t_dp_status s_status;

    rcpt_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (s_cfg)
    );

    rcpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .o_in_ready (o_in_ready),
        .o_cmd      (s_cmd),
        .i_status   (s_status)
    );

    rcpt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .o_status    (s_status),
        .i_cfg       (s_cfg),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// File: design/rcpt_checker.sv
// Port-level checker for the RC pulse decoder and its bind to the top level.
`default_nettype none

module rcpt_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire rcpt_pkg::t_out_item o_out_data
);
    import rcpt_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before its transfer");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // An invalid signal always commands a zero target.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.signal_valid |-> o_out_data.target_milli == 16'sd0)
        else $error("non-zero target with invalid signal");

    // A lost signal is never reported valid.
    a_lost_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.signal_lost |-> !o_out_data.signal_valid)
        else $error("signal reported both lost and valid");

    // A valid width lies below the upper window bound, so it never saturates.
    a_valid_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.signal_valid |-> o_out_data.pulse_width_us != 16'hFFFF)
        else $error("valid signal with saturated pulse width");

endmodule

bind rc_pulse_to_signed_target_unit rcpt_checker u_rcpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// File: tb/sv/tb_rc_pulse_to_signed_target_unit.sv
// Self-checking testbench for the RC pulse decoder, with its own predictor and random stimulus.
module tb_rc_pulse_to_signed_target_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpt_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 8;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_EVENTS   = 60;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int STALL_LIMIT    = 4000;

    // Clock, reset and the signals around the block.
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Events waiting to be offered and results still to arrive.
    t_in_item  pending_events[$];
    t_out_item expected_results[$];

    // Predictor copy of the decoder state and its registers.
    t_cfg        model_cfg;
    logic [31:0] rise_us      = '0;
    logic [31:0] last_edge_us = '0;
    logic [31:0] width_us     = '0;
    logic        pulse_ok     = 1'b0;

    // Traffic shaping and bookkeeping shared between processes.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_request  = 1'b0;
    bit          in_taken      = 1'b0;
    int unsigned stall_cycles  = 0;
    int unsigned mismatches    = 0;
    int unsigned queued_events = 0;
    logic [31:0] stamp_us      = '0;

    rc_pulse_to_signed_target_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Work out the decoder's response to one event; returns 1 when a result is due.
    function automatic bit predict_decoder(input t_in_item ev, output t_out_item res);
        logic [31:0] since_edge;
        longint      den;
        longint      num;
        longint      tgt;
        bit          lost;
        res = '0;
        if (ev.action == ACT_EDGE) begin
            last_edge_us = ev.time_us;
            if (ev.pin_level) begin
                rise_us = ev.time_us;
            end else begin
                width_us = ev.time_us - rise_us;
                pulse_ok = (width_us > model_cfg.valid_low_us) &&
                           (width_us < model_cfg.valid_high_us);
            end
            return 1'b0;
        end
        // An update first checks the edge timeout, then maps the width.
        since_edge = ev.time_us - last_edge_us;
        lost = since_edge > model_cfg.timeout_us;
        if (lost) begin
            pulse_ok = 1'b0;
        end
        tgt = 0;
        if (pulse_ok && !(width_us > model_cfg.dead_low_us && width_us < model_cfg.dead_high_us))
        begin
            den = longint'(model_cfg.span_max_us) - longint'(model_cfg.span_min_us);
            if (den != 0) begin
                num = (longint'(width_us) - longint'(model_cfg.span_min_us)) *
                      (2 * longint'(model_cfg.target_limit_milli));
                tgt = num / den - longint'(model_cfg.target_limit_milli);
            end
        end
        if (tgt > TGT_MAX) begin
            tgt = TGT_MAX;
        end else if (tgt < TGT_MIN) begin
            tgt = TGT_MIN;
        end
        res.target_milli   = tgt[15:0];
        res.signal_valid   = pulse_ok;
        res.signal_lost    = lost;
        res.pulse_width_us = (width_us > 32'h0000_FFFF) ? 16'hFFFF : width_us[15:0];
        return 1'b1;
    endfunction

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Monitor: checks each result transfer, predicts each input transfer, and
    // ends the run if traffic stops altogether.
    always @(posedge clk) begin : monitor
        t_out_item want;
        bit        moved;
        moved = 1'b0;
        if (rst_n && out_valid && out_ready) begin
            moved = 1'b1;
            if (expected_results.size() == 0) begin
                $display("%0t ns: result with none expected, actual target %0d valid %0b",
                         $time, out_data.target_milli, out_data.signal_valid);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("target_milli", want.target_milli, out_data.target_milli);
                check_field("signal_valid", want.signal_valid, out_data.signal_valid);
                check_field("signal_lost", want.signal_lost, out_data.signal_lost);
                check_field("pulse_width_us", want.pulse_width_us, out_data.pulse_width_us);
            end
        end
        in_taken = in_valid && in_ready;
        if (rst_n && in_taken) begin
            moved = 1'b1;
            if (predict_decoder(in_data, want)) begin
                expected_results.push_back(want);
            end
        end
        if (moved || cfg_we) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Driver: offers the next pending event, idling only between transfers.
    always @(negedge clk) begin : source
        if (!in_valid || in_taken) begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= pending_events.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge clk) begin : sink
        int unsigned hold_left;
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic push_event(input logic act, input logic [31:0] stamp, input logic level);
        t_in_item ev;
        ev.action    = act;
        ev.time_us   = stamp;
        ev.pin_level = level;
        pending_events.push_back(ev);
        queued_events++;
    endtask

    // One register write, mirrored into the predictor's copy.
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_VALID_LOW:  model_cfg.valid_low_us       = value[15:0];
            REG_VALID_HIGH: model_cfg.valid_high_us      = value[15:0];
            REG_DEAD_LOW:   model_cfg.dead_low_us        = value[15:0];
            REG_DEAD_HIGH:  model_cfg.dead_high_us       = value[15:0];
            REG_SPAN_MIN:   model_cfg.span_min_us        = value[15:0];
            REG_SPAN_MAX:   model_cfg.span_max_us        = value[15:0];
            REG_LIMIT:      model_cfg.target_limit_milli = value[14:0];
            REG_TIMEOUT:    model_cfg.timeout_us         = value[23:0];
        endcase
    endtask

    // Writes every register; unused upper data bits carry noise that must be dropped.
    task automatic load_config(input t_cfg c);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        write_reg(REG_VALID_LOW,  {noise[23:16], c.valid_low_us});
        write_reg(REG_VALID_HIGH, {noise[23:16], c.valid_high_us});
        write_reg(REG_DEAD_LOW,   {noise[23:16], c.dead_low_us});
        write_reg(REG_DEAD_HIGH,  {noise[23:16], c.dead_high_us});
        write_reg(REG_SPAN_MIN,   {noise[23:16], c.span_min_us});
        write_reg(REG_SPAN_MAX,   {noise[23:16], c.span_max_us});
        write_reg(REG_LIMIT,      {noise[23:15], c.target_limit_milli});
        write_reg(REG_TIMEOUT,    c.timeout_us);
    endtask

    // Register settings per phase: the reset settings and hand-picked extremes first, then random ones.
    function automatic t_cfg pick_config(input int phase);
        t_cfg c;
        c.valid_low_us       = RST_VALID_LOW;
        c.valid_high_us      = RST_VALID_HIGH;
        c.dead_low_us        = RST_DEAD_LOW;
        c.dead_high_us       = RST_DEAD_HIGH;
        c.span_min_us        = RST_SPAN_MIN;
        c.span_max_us        = RST_SPAN_MAX;
        c.target_limit_milli = RST_LIMIT;
        c.timeout_us         = RST_TIMEOUT;
        case (phase)
            0: begin
                // The block runs at its reset settings.
            end
            1: begin
                // Widest window, empty deadband, full span and largest limit.
                c.valid_low_us       = 16'h0000;
                c.valid_high_us      = 16'hFFFF;
                c.dead_low_us        = 16'h0000;
                c.dead_high_us       = 16'h0000;
                c.span_min_us        = 16'h0000;
                c.span_max_us        = 16'hFFFF;
                c.target_limit_milli = 15'h7FFF;
                c.timeout_us         = 24'hFFFFFF;
            end
            2: begin
                // Zero input span.
                c.span_min_us = 16'd1500;
                c.span_max_us = 16'd1500;
            end
            3: begin
                // Reversed span.
                c.span_min_us = 16'd1800;
                c.span_max_us = 16'd1100;
            end
            4: begin
                // Narrow span drives the target into saturation.
                c.span_min_us        = 16'd1500;
                c.span_max_us        = 16'd1501;
                c.target_limit_milli = 15'h7FFF;
            end
            5: c = '0;
            6: c = '1;
            default: begin
                c.valid_low_us       = 16'($urandom_range(0, 1500));
                c.valid_high_us      = c.valid_low_us + 16'($urandom_range(0, 1500));
                c.dead_low_us        = 16'($urandom_range(1000, 1600));
                c.dead_high_us       = c.dead_low_us + 16'($urandom_range(0, 100));
                c.span_min_us        = 16'($urandom_range(0, 2000));
                c.span_max_us        = 16'($urandom_range(0, 3000));
                c.target_limit_milli = 15'($urandom);
                c.timeout_us         = 24'($urandom_range(0, 400000));
            end
        endcase
        return c;
    endfunction

    // Short hand-picked run at the reset settings: window boundaries, a width
    // inside the deadband, the timeout boundary, timestamp wrap and an oversized width.
    task automatic add_directed();
        push_event(ACT_UPDATE, 32'd0, 1'b0);
        push_event(ACT_EDGE, 32'd5000, 1'b1);
        push_event(ACT_EDGE, 32'd6001, 1'b0);
        push_event(ACT_UPDATE, 32'd6100, 1'b1);
        push_event(ACT_EDGE, 32'd10000, 1'b1);
        push_event(ACT_EDGE, 32'd11999, 1'b0);
        push_event(ACT_UPDATE, 32'd12000, 1'b0);
        push_event(ACT_EDGE, 32'd20000, 1'b1);
        push_event(ACT_EDGE, 32'd21000, 1'b0);
        push_event(ACT_UPDATE, 32'd21000, 1'b1);
        push_event(ACT_EDGE, 32'd30000, 1'b1);
        push_event(ACT_EDGE, 32'd32000, 1'b0);
        push_event(ACT_UPDATE, 32'd32001, 1'b0);
        push_event(ACT_EDGE, 32'd40000, 1'b1);
        push_event(ACT_EDGE, 32'd41450, 1'b0);
        push_event(ACT_UPDATE, 32'd241450, 1'b1);
        push_event(ACT_UPDATE, 32'd241451, 1'b0);
        push_event(ACT_EDGE, 32'hFFFF_FF00, 1'b1);
        push_event(ACT_EDGE, 32'h0000_0400, 1'b0);
        push_event(ACT_UPDATE, 32'h0000_0500, 1'b1);
        push_event(ACT_EDGE, 32'd500000, 1'b1);
        push_event(ACT_EDGE, 32'hFFFF_FFFF, 1'b0);
        push_event(ACT_UPDATE, 32'hFFFF_FFFF, 1'b1);
    endtask

    // Mostly complete pulses followed by updates, with some stray edges and
    // updates at arbitrary moments mixed in.
    task automatic add_random_burst();
        int unsigned pick;
        int unsigned sel;
        int unsigned lo;
        int unsigned hi;
        int unsigned w;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            stamp_us = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        end
        if (pick < 70) begin
            stamp_us += $urandom_range(0, 20000);
            push_event(ACT_EDGE, stamp_us, 1'b1);
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                lo = (model_cfg.valid_low_us > 20) ? model_cfg.valid_low_us - 20 : 0;
                hi = model_cfg.valid_high_us + 20;
            end else if (sel < 80) begin
                lo = (model_cfg.dead_low_us > 3) ? model_cfg.dead_low_us - 3 : 0;
                hi = model_cfg.dead_high_us + 3;
            end else begin
                lo = model_cfg.span_min_us;
                hi = model_cfg.span_max_us;
            end
            if (hi < lo) begin
                w  = lo;
                lo = hi;
                hi = w;
            end
            w = (sel < 90) ? $urandom_range(hi, lo) : $urandom;
            stamp_us += w;
            push_event(ACT_EDGE, stamp_us, 1'b0);
            repeat ($urandom_range(1, 3)) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    gap = $urandom_range(0, 2000);
                end else if (sel < 90) begin
                    gap = model_cfg.timeout_us + $urandom_range(0, 4) - 2;
                end else begin
                    gap = $urandom;
                end
                stamp_us += gap;
                push_event(ACT_UPDATE, stamp_us, 1'($urandom_range(0, 1)));
            end
        end else if (pick < 88) begin
            stamp_us += $urandom_range(0, 3000);
            push_event(ACT_EDGE, stamp_us, 1'($urandom_range(0, 1)));
        end else begin
            stamp_us = $urandom;
            push_event(ACT_UPDATE, stamp_us, 1'($urandom_range(0, 1)));
        end
    endtask

    // Main sequence: reset, then phases of settings, traffic shaping and events.
    initial begin : stimulus
        model_cfg = pick_config(0);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                load_config(pick_config(phase));
            end
            @(posedge clk);
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 72;
                end
                default: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 18;
                end
            endcase
            if (phase == PRESSURE_PHASE) begin
                hold_request = 1'b1;
            end
            queued_events = 0;
            stamp_us = $urandom;
            if (phase == 0) begin
                add_directed();
            end else begin
                while (queued_events < PHASE_EVENTS) begin
                    add_random_burst();
                end
            end
            // Let everything drain, then allow for an edge still in progress.
            do @(posedge clk);
            while (pending_events.size() != 0 || in_valid || expected_results.size() != 0);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
